/* sv/ppsts_pkg.sv */
// Package for the PPS-disciplined NTP timestamper.
// Holds the command codes, register map, reset values and the result bookkeeping struct.
// No dependencies.
`timescale 1ns / 1ps

package ppsts_pkg;

  // Item commands carried in tuser
  typedef enum logic [1:0] {
    CMD_PPS   = 2'd0,
    CMD_FIX   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Register map, word index taken from paddr[4:2]
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_WIN_LO    = 3'd0;
  localparam logic [2:0] REG_WIN_HI    = 3'd1;
  localparam logic [2:0] REG_STALE     = 3'd2;
  localparam logic [2:0] REG_EPOCH_NTP = 3'd3;
  localparam logic [2:0] REG_MIN_FIX   = 3'd4;

  // Register reset values
  localparam logic [31:0] RST_WIN_LO    = 32'd900000;
  localparam logic [31:0] RST_WIN_HI    = 32'd1100000;
  localparam logic [31:0] RST_STALE     = 32'd1100000;
  localparam logic [31:0] RST_EPOCH_NTP = 32'd2208988800;
  localparam logic [31:0] RST_MIN_FIX   = 32'd1735689600;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 104;

  // Per-item bookkeeping that rides along the arithmetic pipeline
  typedef struct packed {
    logic        answer;   // query while precise: report a timestamp
    logic        stale;    // offset beyond stale limit: drop whole seconds
    logic        precise;
    logic        pps_acc;
    logic        locked;
    logic [31:0] edges;
    logic [31:0] base;     // epoch second plus NTP era offset
  } meta_t;

endpackage

/* sv/pps_disciplined_ntp_timestamper.sv */
// Top level of the PPS-disciplined NTP timestamper: state update and timestamp pipeline.
// Depends on ppsts_pkg for command codes, register map and the meta_t struct.
// Contains the APB-style register file and the stream channels.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one item per handshake; in_tuser is the command (PPS edge, GPS fix,
//           timestamp query), in_tdata carries the capture time and fix epoch.
//   out_* : exactly one result item per input item, in order.
//   cfg_* : APB-style register port, write only while the block is idle.
// Pipeline: input register, state update stage, five arithmetic stages and
// output register. Throughput: one item per cycle while the output is not
// stalled. The time base state is updated in the stage right after the
// input register, so each item sees the state left by the one before. The
// seconds/fraction split by TICKS_PER_SECOND is done by two reciprocal
// multiplies, each followed by a product and a small correction, one
// multiplier per stage.
// Reset: time base state cleared (not locked, no PPS), registers take their
// default values, pipeline emptied; the block is ready right away.
// Stall: when out_tready is low with a result waiting, the whole pipeline
// holds and in_tready drops in the same cycle.
module pps_disciplined_ntp_timestamper
  import ppsts_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // [31:0] capture_us, [63:32] fix_epoch
  input  logic [IN_TUSER_W-1:0]   in_tuser,   // [1:0] cmd
  // Result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // [31:0] stamp_sec, [63:32] stamp_frac,
                                              // [64] precise, [65] pps_accepted,
                                              // [66] locked_now, [98:67] edge_total,
                                              // [103:99] zero
  // Configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  // Divider constants derived from the tick rate
  localparam longint unsigned TPS        = 64'(TICKS_PER_SECOND);
  localparam int unsigned     RW         = $clog2(TICKS_PER_SECOND);
  localparam int unsigned     K          = RW - 1;
  localparam int unsigned     EW         = RW + 2;
  localparam longint unsigned RECIP_WIDE = (64'd1 << (32 + K)) / TPS;
  localparam logic [31:0]     RECIP      = RECIP_WIDE[31:0];
  localparam longint unsigned QMAX       = 64'hFFFF_FFFF / TPS;
  localparam int unsigned     QW         = $clog2(QMAX + 1);
  localparam logic [31:0]     TPS_32     = TPS[31:0];
  localparam longint unsigned TPS2_W     = 2 * TPS;
  localparam longint unsigned TPS3_W     = 3 * TPS;
  localparam logic [31:0]     TPS2_32    = TPS2_W[31:0];
  localparam logic [EW-1:0]   TPS_E      = TPS[EW-1:0];
  localparam logic [EW-1:0]   TPS2_E     = TPS2_W[EW-1:0];
  localparam logic [EW-1:0]   TPS3_E     = TPS3_W[EW-1:0];

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] win_lo_r, win_hi_r, stale_r, epoch_ntp_r, min_fix_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write on the access cycle; indexes past the map are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_lo_r    <= RST_WIN_LO;
      win_hi_r    <= RST_WIN_HI;
      stale_r     <= RST_STALE;
      epoch_ntp_r <= RST_EPOCH_NTP;
      min_fix_r   <= RST_MIN_FIX;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIN_LO:    win_lo_r    <= cfg_pwdata;
        REG_WIN_HI:    win_hi_r    <= cfg_pwdata;
        REG_STALE:     stale_r     <= cfg_pwdata;
        REG_EPOCH_NTP: epoch_ntp_r <= cfg_pwdata;
        REG_MIN_FIX:   min_fix_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_WIN_LO:    cfg_prdata = win_lo_r;
      REG_WIN_HI:    cfg_prdata = win_hi_r;
      REG_STALE:     cfg_prdata = stale_r;
      REG_EPOCH_NTP: cfg_prdata = epoch_ntp_r;
      REG_MIN_FIX:   cfg_prdata = min_fix_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: all stages move together
  // ---------------------------------------------------------------------
  logic       adv;
  logic [6:0] vld_r;
  logic       out_vld_r;

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[5:0], in_tvalid};
      out_vld_r <= vld_r[6];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic [1:0]  cmd0_r;
  logic [31:0] cap0_r, fix0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r <= in_tuser[1:0];
      cap0_r <= in_tdata[31:0];
      fix0_r <= in_tdata[63:32];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: time base state update
  // ---------------------------------------------------------------------
  logic [31:0] last_edge_r, last_edge_nxt;
  logic [31:0] epoch_r, epoch_nxt;
  logic        locked_r, locked_nxt;
  logic        live_r, live_nxt;
  logic [31:0] edges_r, edges_nxt;
  logic [31:0] interval;
  logic        edge_ok, fix_ok, is_query;

  assign interval = cap0_r - last_edge_r;
  assign edge_ok  = (cmd0_r == CMD_PPS) && (interval > win_lo_r) && (interval < win_hi_r);
  assign fix_ok   = (cmd0_r == CMD_FIX) && (fix0_r >= min_fix_r);
  assign is_query = (cmd0_r == CMD_QUERY);

  // Next state; hold unless an edge or fix qualifies
  always_comb begin
    last_edge_nxt = last_edge_r;
    epoch_nxt     = epoch_r;
    locked_nxt    = locked_r;
    live_nxt      = live_r;
    edges_nxt     = edges_r;
    unique case (cmd0_r)
      CMD_PPS: begin
        if (edge_ok) begin
          last_edge_nxt = cap0_r;
          edges_nxt     = edges_r + 32'd1;
          live_nxt      = 1'b1;
          if (locked_r) begin
            epoch_nxt = epoch_r + 32'd1;
          end
        end
      end
      CMD_FIX: begin
        if (fix_ok) begin
          epoch_nxt  = fix0_r;
          locked_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      epoch_r     <= '0;
      locked_r    <= 1'b0;
      live_r      <= 1'b0;
      edges_r     <= '0;
    end else if (adv && vld_r[0]) begin
      last_edge_r <= last_edge_nxt;
      epoch_r     <= epoch_nxt;
      locked_r    <= locked_nxt;
      live_r      <= live_nxt;
      edges_r     <= edges_nxt;
    end
  end

  meta_t       meta1_nxt;
  meta_t       meta1_r, meta2_r, meta3_r, meta4_r, meta5_r, meta6_r;
  logic [31:0] off1_r, off2_r, off3_r;

  // Collect the per-item flags; a query leaves the epoch untouched
  always_comb begin
    meta1_nxt.precise = locked_nxt && live_nxt;
    meta1_nxt.answer  = is_query && locked_nxt && live_nxt;
    meta1_nxt.stale   = interval > stale_r;
    meta1_nxt.pps_acc = edge_ok;
    meta1_nxt.locked  = locked_nxt;
    meta1_nxt.edges   = edges_nxt;
    meta1_nxt.base    = epoch_r + epoch_ntp_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta1_r <= meta1_nxt;
      off1_r  <= interval;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: quotient estimate by reciprocal multiply (low by at most one)
  // ---------------------------------------------------------------------
  logic [63:0]   qprod2;
  logic [QW-1:0] q2_r;

  assign qprod2 = {32'd0, off1_r} * {32'd0, RECIP};

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_r    <= qprod2[32+K +: QW];
      off2_r  <= off1_r;
      meta2_r <= meta1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: back-multiply the estimate
  // ---------------------------------------------------------------------
  logic [31:0]   qt3;
  logic [31:0]   qt3_r;
  logic [QW-1:0] q3_r;

  assign qt3 = {{(32-QW){1'b0}}, q2_r} * TPS_32;

  always_ff @(posedge clk) begin
    if (adv) begin
      qt3_r   <= qt3;
      q3_r    <= q2_r;
      off3_r  <= off2_r;
      meta3_r <= meta2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: remainder and one-step correction
  // ---------------------------------------------------------------------
  logic [31:0]   r0_4, r1_4;
  logic          qfix4;
  logic [QW-1:0] q4_r;
  logic [RW-1:0] r4_r;

  assign r0_4  = off3_r - qt3_r;
  assign qfix4 = r0_4 >= TPS_32;
  assign r1_4  = qfix4 ? (r0_4 - TPS_32) : r0_4;

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_r    <= q3_r + {{(QW-1){1'b0}}, qfix4};
      r4_r    <= r1_4[RW-1:0];
      meta4_r <= meta3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: fraction estimate, remainder * 2^32 / ticks (low by at most two)
  // ---------------------------------------------------------------------
  logic [RW+31:0] fprod5;
  logic [31:0]    f5_r;
  logic [QW-1:0]  q5_r;

  assign fprod5 = {32'd0, r4_r} * {{RW{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (adv) begin
      f5_r    <= fprod5[K +: 32];
      q5_r    <= q4_r;
      meta5_r <= meta4_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: low bits of fraction estimate times ticks
  // ---------------------------------------------------------------------
  logic [EW-1:0] ft6;
  logic [EW-1:0] ft6_r;
  logic [31:0]   f6_r;
  logic [QW-1:0] q6_r;

  assign ft6 = f5_r[EW-1:0] * TPS_E;

  always_ff @(posedge clk) begin
    if (adv) begin
      ft6_r   <= ft6;
      f6_r    <= f5_r;
      q6_r    <= q5_r;
      meta6_r <= meta5_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: fraction correction, seconds sum, output register
  // ---------------------------------------------------------------------
  logic [EW-1:0] e7;
  logic [31:0]   frac7, secs7, qsec7;
  logic [31:0]   out_secs_r, out_frac_r, out_edges_r;
  logic          out_precise_r, out_pps_r, out_locked_r;

  // Residue of remainder*2^32 against estimate*ticks; low 2^32 bits are zero
  assign e7    = {EW{1'b0}} - ft6_r;
  assign frac7 = f6_r + ((e7 >= TPS2_E) ? 32'd2 : (e7 >= TPS_E) ? 32'd1 : 32'd0);
  assign qsec7 = meta6_r.stale ? 32'd0 : {{(32-QW){1'b0}}, q6_r};
  assign secs7 = meta6_r.base + qsec7;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_secs_r    <= meta6_r.answer ? secs7 : 32'd0;
      out_frac_r    <= meta6_r.answer ? frac7 : 32'd0;
      out_precise_r <= meta6_r.precise;
      out_pps_r     <= meta6_r.pps_acc;
      out_locked_r  <= meta6_r.locked;
      out_edges_r   <= meta6_r.edges;
    end
  end

  assign out_tdata = {5'd0, out_edges_r, out_locked_r, out_pps_r, out_precise_r,
                      out_frac_r, out_secs_r};

`ifndef SYNTHESIS
  // Quotient estimate is never more than one short
  a_quot_corr: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> r0_4 < TPS2_32)
    else $error("quotient correction out of range");

  // Fraction estimate is never more than two short
  a_frac_corr: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> e7 < TPS3_E)
    else $error("fraction correction out of range");

  // Edge count steps by one, and only while an item leaves the input register
  a_edge_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (edges_r != $past(edges_r)) |->
      $past(vld_r[0] && adv) && (edges_r == $past(edges_r) + 32'd1))
    else $error("edge count changed unexpectedly");

  // No timestamp is reported without a precise time base
  a_no_ts: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_precise_r |-> (out_secs_r == 32'd0) && (out_frac_r == 32'd0))
    else $error("timestamp reported while not precise");
`endif

endmodule

/* dv/pps_disciplined_ntp_timestamper_tb.sv */
// Self-checking testbench for the PPS-disciplined NTP timestamper.
// Predicts every result item from its own copy of the time base and the registers.
// Depends on ppsts_pkg and the pps_disciplined_ntp_timestamper RTL.
`timescale 1ns / 1ps

import ppsts_pkg::*;

// One predicted result item
typedef struct {
  logic [31:0] seconds;
  logic [31:0] fraction;
  logic        precise;
  logic        pps_acc;
  logic        locked;
  logic [31:0] edges;
} stamp_t;

// Time base predictor plus the store of expected stamps
class stamp_scoreboard;
  localparam longint unsigned TPS = 1000000;

  logic [31:0] win_lo, win_hi, stale_lim, era_offset, min_fix;
  logic [31:0] last_edge, epoch_sec, edge_count;
  logic        locked, pps_live;
  stamp_t      expected_stamps[$];
  int          errors;
  int          compared;

  function new();
    win_lo     = RST_WIN_LO;
    win_hi     = RST_WIN_HI;
    stale_lim  = RST_STALE;
    era_offset = RST_EPOCH_NTP;
    min_fix    = RST_MIN_FIX;
    last_edge  = '0;
    epoch_sec  = '0;
    edge_count = '0;
    locked     = 1'b0;
    pps_live   = 1'b0;
    errors     = 0;
    compared   = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_WIN_LO:    win_lo = val;
      REG_WIN_HI:    win_hi = val;
      REG_STALE:     stale_lim = val;
      REG_EPOCH_NTP: era_offset = val;
      REG_MIN_FIX:   min_fix = val;
      default:       ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_WIN_LO:    return win_lo;
      REG_WIN_HI:    return win_hi;
      REG_STALE:     return stale_lim;
      REG_EPOCH_NTP: return era_offset;
      default:       return min_fix;
    endcase
  endfunction

  function int pending();
    return expected_stamps.size();
  endfunction

  // Advance the time base by one accepted item and queue its stamp
  function void note_item(logic [1:0] cmd, logic [31:0] cap, logic [31:0] fix);
    logic [31:0] interval;
    logic [31:0] offset;
    logic [31:0] rem;
    logic [63:0] num;
    stamp_t      s;
    s.seconds  = '0;
    s.fraction = '0;
    s.pps_acc  = 1'b0;
    if (cmd == CMD_PPS) begin
      interval = cap - last_edge;
      if (interval > win_lo && interval < win_hi) begin
        last_edge  = cap;
        edge_count = edge_count + 32'd1;
        pps_live   = 1'b1;
        if (locked) epoch_sec = epoch_sec + 32'd1;
        s.pps_acc = 1'b1;
      end
    end else if (cmd == CMD_FIX) begin
      if (fix >= min_fix) begin
        epoch_sec = fix;
        locked    = 1'b1;
      end
    end else if (cmd == CMD_QUERY) begin
      if (locked && pps_live) begin
        offset = cap - last_edge;
        // drop whole seconds once the last edge is too old
        if (offset > stale_lim) offset = 32'(offset % TPS);
        rem        = 32'(offset % TPS);
        num        = {rem, 32'd0};
        s.seconds  = epoch_sec + era_offset + 32'(offset / TPS);
        s.fraction = 32'(num / TPS);
      end
    end
    s.precise = locked && pps_live;
    s.locked  = locked;
    s.edges   = edge_count;
    expected_stamps.push_back(s);
  endfunction

  function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Compare one result item against the oldest expected stamp
  function void check_stamp(logic [OUT_TDATA_W-1:0] data);
    stamp_t s;
    if (expected_stamps.size() == 0) begin
      errors++;
      $display("%0t unexpected result item expected none actual %h", $time, data);
      return;
    end
    s = expected_stamps.pop_front();
    compared++;
    cmp_field("stamp_sec", s.seconds, data[31:0]);
    cmp_field("stamp_frac", s.fraction, data[63:32]);
    cmp_field("precise", 32'(s.precise), 32'(data[64]));
    cmp_field("pps_accepted", 32'(s.pps_acc), 32'(data[65]));
    cmp_field("locked_now", 32'(s.locked), 32'(data[66]));
    cmp_field("edge_total", s.edges, data[98:67]);
    cmp_field("padding", 32'd0, 32'(data[103:99]));
  endfunction
endclass

module pps_disciplined_ntp_timestamper_tb;

  localparam logic [1:0] CMD_NONE     = 2'd3;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 135;
  localparam int         LIMIT_CYCLES = 300000;
  localparam int         DRAIN_CYCLES = 20;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] capture_us, [63:32] fix_epoch
  logic [IN_TUSER_W-1:0]  in_tuser;   // [1:0] cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] stamp_sec, [63:32] stamp_frac,
                                      // [64] precise, [65] pps_accepted,
                                      // [66] locked_now, [98:67] edge_total, [103:99] zero
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  stamp_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_by_cmd[4];
  int cycles = 0;
  int settings_run = 0;

  pps_disciplined_ntp_timestamper u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted items first, so a same-edge result still finds its stamp
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) sb.check_stamp(out_tdata);
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout with %0d stamps outstanding", $time, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(logic [1:0] cmd, logic [31:0] cap, logic [31:0] fix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {fix, cap};
    sent_by_cmd[cmd]++;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected stamp has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_read(logic [2:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== sb.reg_value(idx)) begin
      sb.errors++;
      $display("%0t mismatch register %0d expected %h actual %h",
               $time, idx, sb.reg_value(idx), cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Load one register setting per phase, extremes and empty windows among them
  task automatic apply_setting(int p);
    logic [31:0] v[5];
    case (p)
      1: v = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
      2: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      3: v = '{32'd500, 32'd501, 32'd2000000, RST_EPOCH_NTP, 32'd1609459200};
      4: v = '{32'd999990, 32'd1000010, 32'd1000000, $urandom,
               $urandom_range(1600000000, 1800000000)};
      5: begin
        v[0] = $urandom_range(2000000);
        v[1] = v[0] + $urandom_range(400000);
        v[2] = $urandom_range(5000000);
        v[3] = $urandom;
        v[4] = $urandom;
      end
      7: v = '{$urandom, $urandom, $urandom, $urandom, $urandom};
      default: v = '{RST_WIN_LO, RST_WIN_HI, RST_STALE, RST_EPOCH_NTP, RST_MIN_FIX};
    endcase
    cfg_write(REG_WIN_LO, v[0]);
    cfg_write(REG_WIN_HI, v[1]);
    cfg_write(REG_STALE, v[2]);
    cfg_write(REG_EPOCH_NTP, v[3]);
    cfg_write(REG_MIN_FIX, v[4]);
    // a write past the map must leave every register alone
    cfg_write(REG_UNMAPPED, $urandom);
    for (int i = 0; i < 5; i++) cfg_read(3'(i));
    settings_run++;
  endtask

  // PPS capture time a plausible interval after the last accepted edge
  function automatic logic [31:0] next_edge();
    longint unsigned span;
    logic [31:0]     interval;
    span = longint'(sb.win_hi) - longint'(sb.win_lo);
    if (sb.win_hi <= sb.win_lo + 32'd1 || sb.win_hi < sb.win_lo || $urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: interval = sb.win_lo;
        1: interval = sb.win_lo + 32'd1;
        2: interval = sb.win_hi - 32'd1;
        3: interval = sb.win_hi;
        default: interval = $urandom;
      endcase
    end else begin
      interval = sb.win_lo + 32'd1 + 32'(longint'($urandom) % (span - 1));
    end
    return sb.last_edge + interval;
  endfunction

  // Query capture time at an offset from the last accepted edge
  function automatic logic [31:0] query_time();
    logic [31:0] offset;
    case ($urandom_range(9))
      0: offset = sb.stale_lim + 32'($urandom_range(2)) - 32'd1;
      1: offset = $urandom;
      2: offset = 32'($urandom_range(5)) * 32'd1000000 + 32'($urandom_range(999999));
      default: offset = $urandom_range(1100000);
    endcase
    return sb.last_edge + offset;
  endfunction

  // Fix epoch at or just around the minimum accepted epoch, or fully random
  function automatic logic [31:0] fix_epoch();
    longint unsigned room;
    room = 64'hFFFF_FFFF - longint'(sb.min_fix);
    case ($urandom_range(3))
      0: return sb.min_fix - 32'd1;
      1: return $urandom;
      default: return sb.min_fix + 32'($urandom_range(room > 100 ? 100 : int'(room)));
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40)      send_item(CMD_PPS, next_edge(), $urandom);
    else if (r < 52) send_item(CMD_FIX, $urandom, fix_epoch());
    else if (r < 85) send_item(CMD_QUERY, query_time(), $urandom);
    else if (r < 90) send_item(CMD_PPS, $urandom, $urandom);
    else if (r < 95) send_item(CMD_NONE, $urandom, $urandom);
    else             send_item(CMD_FIX, $urandom, $urandom);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: unlocked queries, field extremes, window edges, stale limit
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_PPS, 32'd0, 32'd0);
    send_item(CMD_PPS, 32'd1000000, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 32'd1500000, 32'd0);
    send_item(CMD_FIX, 32'd0, RST_MIN_FIX - 32'd1);
    send_item(CMD_FIX, 32'hFFFF_FFFF, RST_MIN_FIX);
    send_item(CMD_FIX, 32'd0, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, sb.last_edge, 32'd0);
    send_item(CMD_FIX, 32'd0, 32'd0);
    send_item(CMD_PPS, sb.last_edge + RST_WIN_LO, 32'd0);
    send_item(CMD_PPS, sb.last_edge + RST_WIN_HI, 32'd0);
    send_item(CMD_PPS, sb.last_edge + RST_WIN_LO + 32'd1, 32'd0);
    send_item(CMD_PPS, sb.last_edge + RST_WIN_HI - 32'd1, 32'd0);
    send_item(CMD_QUERY, sb.last_edge + 32'd999999, 32'd0);
    send_item(CMD_QUERY, sb.last_edge + RST_STALE, 32'd0);
    send_item(CMD_QUERY, sb.last_edge + RST_STALE + 32'd1, 32'd0);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_NONE, 32'd0, 32'd0);
    send_item(CMD_FIX, 32'd0, RST_MIN_FIX + 32'd5);
    send_item(CMD_QUERY, sb.last_edge + 32'd500000, 32'd0);
    drain();

    // Random phases, each with a register setting and an idle and stall pattern
    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d edges, %0d fixes, %0d queries, %0d ignored commands over %0d settings",
             sent_by_cmd[CMD_PPS], sent_by_cmd[CMD_FIX], sent_by_cmd[CMD_QUERY],
             sent_by_cmd[CMD_NONE], settings_run);
    $display("compared %0d result items, %0d PPS edges accepted", sb.compared, sb.edge_count);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t %0d expected stamps never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
